### rtl/core/rtp_playout_frame_buffer_core_macros.svh
// ----------------------------------------------------------------------------
// Playout frame buffer assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RTP_PLAYOUT_FRAME_BUFFER_CORE_MACROS_SVH
`define RTP_PLAYOUT_FRAME_BUFFER_CORE_MACROS_SVH

// same-cycle implication
`define RPFB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtp playout frame buffer check failed");

// next-cycle implication
`define RPFB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtp playout frame buffer check failed");

`endif

### rtl/core/rpfb_pkg.sv
// ----------------------------------------------------------------------------
// rpfb_pkg
// Types and codes shared by the playout frame buffer core and its checker.
// ----------------------------------------------------------------------------
package rpfb_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXPIRE = 2'd1,
		OP_DECODE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;

	localparam logic [2:0] ST_MERGED   = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_LATE     = 3'd2;
	localparam logic [2:0] ST_VERY_OLD = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam int          TS_W        = 32;
	localparam int          TIME_W      = 48;
	localparam int          DELAY_W     = 20;
	localparam logic [19:0] DELAY_RESET = 20'd32000;

	typedef struct packed {
		logic [TS_W-1:0]   ts;
		logic [TIME_W-1:0] due;
		logic              marker;
		logic              decoded;
	} frame_rec_t;

endpackage

### rtl/core/rtp_playout_frame_buffer_core.sv
// ----------------------------------------------------------------------------
// rtp_playout_frame_buffer_core
// Ordered ring of frame records for an RTP playout (jitter) buffer.
// ----------------------------------------------------------------------------
// One item at a time: insert, expire, decode or no-op, each giving one result
// item. All frame records sit in one single-port memory with a registered read;
// a sequencer walks it one record at a time (read, then evaluate through one
// shared magnitude comparator). No new item is taken until the last one is
// done; the records read per item are 0 to 2 for insert, up to the number of
// live frames (at most FRAME_SLOTS) for expire and decode, 0 for no-op.
// Results wait in an output register; no clearing pass runs after reset,
// the buffer is simply empty.
module rtp_playout_frame_buffer_core #(
	parameter int FRAME_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rpfb_pkg::DELAY_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [rpfb_pkg::TS_W-1:0]   rtp_ts,
	input  logic                        marker,
	input  logic [rpfb_pkg::TIME_W-1:0] now_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  insert_status,
	output logic [3:0]                  frame_slot,
	output logic [4:0]                  removed_count,
	output logic                        decode_found,
	output logic [rpfb_pkg::TS_W-1:0]   decoded_ts
);
	import rpfb_pkg::*;

	localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int CW = $clog2(FRAME_SLOTS + 1);

	state_t state_q, state_d;

	logic [DELAY_W-1:0] delay_q;
	logic [SW-1:0]      head_q, head_d;
	logic [CW-1:0]      count_q, count_d;

	op_t                op_q;
	logic [TS_W-1:0]    ts_q;
	logic               marker_q;
	logic [TIME_W-1:0]  now_q;

	logic [CW-1:0]      k_q, k_d;
	logic [SW-1:0]      ptr_q, ptr_d;
	logic               hchk_q, hchk_d;

	logic [2:0]         res_status_q, res_status_d;
	logic [SW-1:0]      res_slot_q, res_slot_d;
	logic               res_found_q, res_found_d;
	logic [TS_W-1:0]    res_ts_q, res_ts_d;

	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [3:0]         out_slot_q;
	logic [4:0]         out_removed_q;
	logic               out_found_q;
	logic [TS_W-1:0]    out_ts_q;

	frame_rec_t         mem [FRAME_SLOTS];
	frame_rec_t         rd_q;
	logic               mem_we;
	logic [SW-1:0]      mem_waddr;
	frame_rec_t         mem_wdata;

	logic [TIME_W-1:0]  cmp_a, cmp_b;
	logic               cmp_gt, ts_eq, eligible, last_k, out_free;
	logic [TIME_W:0]    due_sum;
	logic [TIME_W-1:0]  due_new;
	logic [SW-1:0]      new_pos;
	frame_rec_t         new_rec;

	function automatic logic [SW-1:0] ring_add(input logic [SW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW:0] s;
		s = (SW+1)'(base) + (SW+1)'(off);
		if (s >= (SW+1)'(FRAME_SLOTS))
			s = s - (SW+1)'(FRAME_SLOTS);
		return s[SW-1:0];
	endfunction

	// shared comparator: timestamps for insert, times for expire/decode
	always_comb begin
		if (op_q == OP_INSERT) begin
			cmp_a = {{(TIME_W-TS_W){1'b0}}, rd_q.ts};
			cmp_b = {{(TIME_W-TS_W){1'b0}}, ts_q};
		end else begin
			cmp_a = now_q;
			cmp_b = rd_q.due;
		end
	end
	assign cmp_gt   = cmp_a > cmp_b;
	assign ts_eq    = rd_q.ts == ts_q;
	assign eligible = !rd_q.decoded && cmp_gt && rd_q.marker;
	assign last_k   = (k_q + CW'(1)) == count_q;
	assign out_free = !out_valid_q || out_ready;

	assign due_sum = {1'b0, now_q} + (TIME_W+1)'(delay_q);
	assign due_new = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];
	assign new_pos = ring_add(head_q, count_q);

	always_comb begin
		new_rec.ts      = ts_q;
		new_rec.due     = due_new;
		new_rec.marker  = marker_q;
		new_rec.decoded = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_PREP;
			end
			S_PREP: begin
				case (op_q)
					OP_INSERT, OP_EXPIRE, OP_DECODE:
						state_d = (count_q == '0) ? S_DONE : S_READ;
					default: state_d = S_DONE;
				endcase
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				case (op_q)
					OP_INSERT:
						state_d = (!hchk_q && !ts_eq && cmp_gt) ? S_READ : S_DONE;
					OP_EXPIRE:
						state_d = (cmp_gt && count_q != CW'(1)) ? S_READ : S_DONE;
					OP_DECODE:
						state_d = (eligible || last_k) ? S_DONE : S_READ;
					default: state_d = S_DONE;
				endcase
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		k_d          = k_q;
		ptr_d        = ptr_q;
		hchk_d       = hchk_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_found_d  = res_found_q;
		res_ts_d     = res_ts_q;
		mem_we       = 1'b0;
		mem_waddr    = ptr_q;
		mem_wdata    = rd_q;
		case (state_q)
			S_PREP: begin
				res_status_d = ST_MERGED;
				res_slot_d   = '0;
				res_found_d  = 1'b0;
				res_ts_d     = '0;
				k_d          = '0;
				hchk_d       = 1'b0;
				ptr_d        = head_q;
				if (op_q == OP_INSERT) begin
					if (count_q == '0) begin
						mem_we       = 1'b1;
						mem_waddr    = new_pos;
						mem_wdata    = new_rec;
						count_d      = count_q + CW'(1);
						res_status_d = ST_NEW;
						res_slot_d   = new_pos;
					end else begin
						ptr_d = ring_add(head_q, count_q - CW'(1));
					end
				end
			end
			S_EVAL: begin
				case (op_q)
					OP_INSERT: begin
						if (hchk_q) begin
							res_status_d = cmp_gt ? ST_VERY_OLD : ST_LATE;
						end else if (ts_eq) begin
							mem_we           = 1'b1;
							mem_wdata.marker = rd_q.marker | marker_q;
							res_status_d     = ST_MERGED;
							res_slot_d       = ptr_q;
						end else if (cmp_gt) begin
							// newer frame already open: compare against the oldest
							ptr_d  = head_q;
							hchk_d = 1'b1;
						end else if (count_q == CW'(FRAME_SLOTS)) begin
							res_status_d = ST_FULL;
						end else begin
							mem_we       = 1'b1;
							mem_waddr    = new_pos;
							mem_wdata    = new_rec;
							count_d      = count_q + CW'(1);
							res_status_d = ST_NEW;
							res_slot_d   = new_pos;
						end
					end
					OP_EXPIRE: begin
						if (cmp_gt) begin
							head_d  = ring_add(head_q, CW'(1));
							ptr_d   = ring_add(head_q, CW'(1));
							count_d = count_q - CW'(1);
							k_d     = k_q + CW'(1);
						end
					end
					OP_DECODE: begin
						if (eligible) begin
							mem_we            = 1'b1;
							mem_wdata.decoded = 1'b1;
							res_found_d       = 1'b1;
							res_slot_d        = ptr_q;
							res_ts_d          = rd_q.ts;
						end else begin
							k_d   = k_q + CW'(1);
							ptr_d = ring_add(head_q, k_q + CW'(1));
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			delay_q     <= DELAY_RESET;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (cfg_we)
				delay_q <= cfg_wdata;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q     <= op_t'(op);
			ts_q     <= rtp_ts;
			marker_q <= marker;
			now_q    <= now_time;
		end
		k_q          <= k_d;
		ptr_q        <= ptr_d;
		hchk_q       <= hchk_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_found_q  <= res_found_d;
		res_ts_q     <= res_ts_d;
		if (state_q == S_DONE && out_free) begin
			out_status_q  <= (op_q == OP_INSERT) ? res_status_q : ST_MERGED;
			out_slot_q    <= 4'(res_slot_q);
			out_removed_q <= (op_q == OP_EXPIRE) ? 5'(k_q) : 5'd0;
			out_found_q   <= res_found_q;
			out_ts_q      <= res_ts_q;
		end
	end

	// frame record memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (state_q == S_READ)
			rd_q <= mem[ptr_q];
	end

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign insert_status = out_status_q;
	assign frame_slot    = out_slot_q;
	assign removed_count = out_removed_q;
	assign decode_found  = out_found_q;
	assign decoded_ts    = out_ts_q;

endmodule

### rtl/core/rpfb_checker.sv
// ----------------------------------------------------------------------------
// rpfb_checker
// Port-level checks for the playout frame buffer core, bound into the core module.
// ----------------------------------------------------------------------------
`include "rtp_playout_frame_buffer_core_macros.svh"

module rpfb_checker #(
	parameter int FRAME_SLOTS = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [2:0]                  insert_status,
	input logic [4:0]                  removed_count,
	input logic                        decode_found,
	input logic [rpfb_pkg::TS_W-1:0]   decoded_ts
);
	import rpfb_pkg::*;

	logic status_set, other_clear, fields_in_range;

	assign status_set      = insert_status != ST_MERGED;
	assign other_clear     = !decode_found && removed_count == 5'd0;
	assign fields_in_range = 32'(removed_count) <= 32'(FRAME_SLOTS) && insert_status <= ST_FULL;

	// every item runs through the sequencer, so intake closes right after an accept
	`RPFB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a drop or new-frame status only comes from an insert
	`RPFB_ASSERT_NOW(a_insert_fields, out_valid && status_set, other_clear)

	// no selected frame means an empty timestamp
	`RPFB_ASSERT_NOW(a_decode_empty, out_valid && !decode_found, decoded_ts == '0)

	// expire never pops more than the ring holds, and the status code stays in range
	`RPFB_ASSERT_NOW(a_removed_bound, out_valid, fields_in_range)

endmodule

bind rtp_playout_frame_buffer_core rpfb_checker #(.FRAME_SLOTS(FRAME_SLOTS)) u_rpfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.insert_status (insert_status),
	.removed_count (removed_count),
	.decode_found  (decode_found),
	.decoded_ts    (decoded_ts)
);

### dv/rpfb_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfb_frame_checker
// Watches the item channels of the playout frame buffer. It keeps its own
// ring of frame records and delay setting, predicts the result of every
// accepted item and compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module rpfb_frame_checker #(
	parameter int FRAME_SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rpfb_pkg::DELAY_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [rpfb_pkg::TS_W-1:0]    rtp_ts,
	input  logic                         marker,
	input  logic [rpfb_pkg::TIME_W-1:0]  now_time,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [2:0]                   insert_status,
	input  logic [3:0]                   frame_slot,
	input  logic [4:0]                   removed_count,
	input  logic                         decode_found,
	input  logic [rpfb_pkg::TS_W-1:0]    decoded_ts,
	output int unsigned                  pending,
	output int unsigned                  fail_count
);
	import rpfb_pkg::*;

	typedef struct packed {
		logic [2:0]      status;
		logic [3:0]      slot;
		logic [4:0]      removed;
		logic            found;
		logic [TS_W-1:0] ts;
	} frame_result_t;

	frame_rec_t          ring [FRAME_SLOTS];
	int unsigned         head;
	int unsigned         count;
	logic [DELAY_W-1:0]  delay_us;
	frame_result_t       predicted_results [$];
	int unsigned         mismatches = 0;

	assign fail_count = mismatches;

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic apply_frame_op(input logic [1:0] code, input logic [TS_W-1:0] ts,
			input logic mk, input logic [TIME_W-1:0] t, output frame_result_t res);
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] due_at;
		int unsigned       newest, pos, k;
		res = '0;
		newest = 0;
		case (op_t'(code))
			OP_INSERT: begin
				if (count != 0)
					newest = (head + count - 1) % FRAME_SLOTS;
				if (count != 0 && ring[newest].ts == ts) begin
					ring[newest].marker = ring[newest].marker | mk;
					res.status = ST_MERGED;
					res.slot = 4'(newest);
				end else if (count != 0 && ring[newest].ts > ts) begin
					res.status = (ring[head].ts > ts) ? ST_VERY_OLD : ST_LATE;
				end else if (count >= FRAME_SLOTS) begin
					res.status = ST_FULL;
				end else begin
					// due time saturates at the top of the time range
					sum = {1'b0, t} + (TIME_W+1)'(delay_us);
					due_at = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
					pos = (head + count) % FRAME_SLOTS;
					ring[pos] = '{ts: ts, due: due_at, marker: mk, decoded: 1'b0};
					count++;
					res.status = ST_NEW;
					res.slot = 4'(pos);
				end
			end
			OP_EXPIRE: begin
				while (count != 0 && t > ring[head].due) begin
					head = (head + 1) % FRAME_SLOTS;
					count--;
					res.removed++;
				end
			end
			OP_DECODE: begin
				for (k = 0; k < count && !res.found; k++) begin
					pos = (head + k) % FRAME_SLOTS;
					if (!ring[pos].decoded && t > ring[pos].due && ring[pos].marker) begin
						ring[pos].decoded = 1'b1;
						res.found = 1'b1;
						res.slot = 4'(pos);
						res.ts = ring[pos].ts;
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		frame_result_t res, want;
		if (!arst_n) begin
			head = 0;
			count = 0;
			delay_us = DELAY_RESET;
			foreach (ring[i])
				ring[i] = '0;
			predicted_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				delay_us = cfg_wdata;
			if (in_valid && in_ready) begin
				apply_frame_op(op, rtp_ts, marker, now_time, res);
				predicted_results.push_back(res);
			end
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					flag_mismatch("unrequested result", 1, 0);
				end else begin
					want = predicted_results.pop_front();
					if (insert_status !== want.status)
						flag_mismatch("insert_status", insert_status, want.status);
					if (frame_slot !== want.slot)
						flag_mismatch("frame_slot", frame_slot, want.slot);
					if (removed_count !== want.removed)
						flag_mismatch("removed_count", removed_count, want.removed);
					if (decode_found !== want.found)
						flag_mismatch("decode_found", decode_found, want.found);
					if (decoded_ts !== want.ts)
						flag_mismatch("decoded_ts", decoded_ts, want.ts);
				end
			end
			pending <= predicted_results.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the playout frame buffer core: a directed opening (empty buffer,
// merge, full ring, late and very old drops, due-time edges), then random
// phases of packet streams under different playout delays, and a closing
// check of due-time saturation. Results are checked by rpfb_frame_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import rpfb_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 160;
	localparam int RUN_LIMIT_NS  = 2_000_000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [DELAY_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_NOP;
	logic [TS_W-1:0]    rtp_ts = '0;
	logic               marker = 1'b0;
	logic [TIME_W-1:0]  now_time = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         insert_status;
	logic [3:0]         frame_slot;
	logic [4:0]         removed_count;
	logic               decode_found;
	logic [TS_W-1:0]    decoded_ts;
	int unsigned        pending;
	int unsigned        fail_count;
	bit                 tx_gappy = 1'b1;

	rtp_playout_frame_buffer_core #(
		.FRAME_SLOTS(16)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.rtp_ts       (rtp_ts),
		.marker       (marker),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.insert_status(insert_status),
		.frame_slot   (frame_slot),
		.removed_count(removed_count),
		.decode_found (decode_found),
		.decoded_ts   (decoded_ts)
	);

	rpfb_frame_checker #(
		.FRAME_SLOTS(16)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.rtp_ts       (rtp_ts),
		.marker       (marker),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.insert_status(insert_status),
		.frame_slot   (frame_slot),
		.removed_count(removed_count),
		.decode_found (decode_found),
		.decoded_ts   (decoded_ts),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_item(input op_t kind, input logic [TS_W-1:0] ts, input logic mk,
			input logic [TIME_W-1:0] t);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_gappy = !tx_gappy;
		gap = tx_gappy ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= kind;
		rtp_ts <= ts;
		marker <= mk;
		now_time <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// drop valid and wait until every outstanding item has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_delay(input logic [DELAY_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side; two long hold-offs let the core back up into its input
	initial begin : rx_side
		int unsigned gap, taken;
		bit no_stall;
		taken = 0;
		no_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 100 == 0)
				no_stall = ($urandom_range(0, 2) == 0);
			gap = no_stall ? 0 : $urandom_range(0, 4);
			if (taken == 400 || taken == 1000)
				gap = HOLD_CYCLES;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
		end
	end

	initial begin : stim
		logic [TIME_W-1:0]  t;
		logic [TS_W-1:0]    ts, cur_ts;
		logic [DELAY_W-1:0] dly;
		int unsigned        r, s, step, phase, n;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset delay of 32000 us
		t = 48'd1000;
		send_item(OP_NOP, '1, 1'b1, '1);
		send_item(OP_DECODE, '0, 1'b0, t);
		send_item(OP_EXPIRE, '0, 1'b0, t);
		send_item(OP_INSERT, 32'd100, 1'b0, t);
		send_item(OP_INSERT, 32'd100, 1'b1, t + 48'd1);
		for (n = 1; n <= 14; n++)
			send_item(OP_INSERT, 32'd100 + n, 1'b1, t + 48'd10);
		send_item(OP_INSERT, 32'hFFFF_FFFE, 1'b1, t + 48'd10);
		send_item(OP_INSERT, 32'hFFFF_FFFE, 1'b0, t + 48'd10);   // merge into a full ring
		send_item(OP_INSERT, 32'hFFFF_FFFF, 1'b1, t + 48'd10);   // ring full
		send_item(OP_INSERT, 32'd50, 1'b1, t + 48'd20);          // below the oldest frame
		send_item(OP_INSERT, 32'd105, 1'b1, t + 48'd20);         // late
		send_item(OP_DECODE, '0, 1'b0, 48'd33000);               // due equals now: not yet
		send_item(OP_DECODE, '0, 1'b0, 48'd33001);
		send_item(OP_DECODE, '0, 1'b0, 48'd33001);               // oldest already decoded
		send_item(OP_EXPIRE, '0, 1'b0, 48'd33001);
		send_item(OP_EXPIRE, '0, 1'b0, 48'd33010);
		send_item(OP_DECODE, '0, 1'b0, 48'd40000);
		send_item(OP_EXPIRE, '0, 1'b0, 48'd40000);
		send_item(OP_INSERT, 32'd0, 1'b1, 48'd40000);            // empty ring again
		send_item(OP_DECODE, '1, 1'b1, 48'd72001);
		send_item(OP_EXPIRE, '1, 1'b1, 48'd72001);

		// random phases; t only moves forward so no frame gets stuck at the head
		for (phase = 1; phase <= 8; phase++) begin
			settle();
			case (phase)
				1: dly = '0;
				2: dly = 20'd1000000;
				3: dly = DELAY_RESET;
				4, 8: dly = 20'($urandom_range(1, 2000));
				default: dly = 20'($urandom_range(0, 1000000));
			endcase
			set_delay(dly);
			t = 48'h1F00_0000_0000 * TIME_W'(phase);
			t[39:0] = {8'($urandom), 32'($urandom)};
			cur_ts = $urandom;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				step = ($urandom_range(0, 19) == 0) ?
					dly + $urandom_range(0, dly / 2 + 100) :
					$urandom_range(0, dly / 16 + 20);
				t = t + TIME_W'(step);
				r = $urandom_range(0, 99);
				if (r < 55) begin
					s = $urandom_range(0, 99);
					if (s < 45) begin
						ts = cur_ts;
					end else if (s < 85) begin
						cur_ts = cur_ts + $urandom_range(1, 3000);
						ts = cur_ts;
					end else if (s < 95) begin
						ts = cur_ts - $urandom_range(1, 20000);
					end else begin
						ts = $urandom;
						if (ts > cur_ts)
							cur_ts = ts;
					end
					send_item(OP_INSERT, ts, ($urandom_range(0, 9) < 4), t);
				end else if (r < 75) begin
					send_item(OP_DECODE, $urandom, 1'($urandom), t);
				end else if (r < 92) begin
					send_item(OP_EXPIRE, $urandom, 1'($urandom), t);
				end else begin
					send_item(op_t'($urandom_range(0, 3)), $urandom, 1'($urandom),
						t - TIME_W'($urandom_range(0, 1000)));
				end
			end
			// empties the ring before the next delay setting
			send_item(OP_EXPIRE, '0, 1'b0, t + TIME_W'(dly) + 48'd5000);
		end

		// due time saturation at the top of the time range
		settle();
		set_delay(20'd1000000);
		ts = $urandom;
		send_item(OP_INSERT, ts, 1'b1, '1 - 48'd5);
		send_item(OP_INSERT, ts, 1'b0, '1);
		send_item(OP_DECODE, '0, 1'b0, '1);
		send_item(OP_EXPIRE, '0, 1'b0, '1);
		settle();

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
